@@ rtl/descending_heap_sorter_core_assert.svh @@
// ----------------------------------------------------------------------------
// descending_heap_sorter_core assertion macros
// Clocked assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DESCENDING_HEAP_SORTER_CORE_ASSERT_SVH
`define DESCENDING_HEAP_SORTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check prop at every rising edge outside reset.
`define DHS_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check cons in the cycle after ante.
`define DHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DHS_ASSERT_CLK(label, clk, rst, prop, msg)
`define DHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/dhs_pkg.sv @@
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared constants and the signed compare of the descending heap sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package dhs_pkg;

  localparam int DEF_MAX_ELEMENTS = 64;
  localparam int VALUE_W          = 32;

  typedef logic [VALUE_W-1:0] value_t;

  // Signed less-than on two's complement patterns.
  function automatic logic value_less(input value_t a, input value_t b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

`default_nettype wire

@@ rtl/descending_heap_sorter_core.sv @@
// ----------------------------------------------------------------------------
// descending_heap_sorter_core
// Collects a set of signed values, heap sorts them in RAM and streams them
// out largest first.
// ----------------------------------------------------------------------------
// Values arrive one beat per cycle while the block is idle and are written
// straight into a store of MAX_ELEMENTS entries. The beat flagged last
// closes the set: the block then stalls its input, builds a min-heap in
// the store and repeatedly moves the root behind the shrinking heap, which
// leaves the store in descending order. The single-ported read side of the
// store sets the pace: each sift level takes separate steps to read the
// left child, read the right child where there is one, and compare and
// write back; each sift ends with a step that places the sifted value, and
// each extraction fetches the root and the tail before sifting. Results
// leave one at a time, the next being read from the store only after the
// previous one has been taken. Beats beyond capacity are dropped and every
// result of that set carries overflowed. The input is stalled from the last
// beat until the final result has been taken, so the next set starts
// cleanly. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "descending_heap_sorter_core_assert.svh"

module descending_heap_sorter_core
  import dhs_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               last,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [VALUE_W-1:0] sorted_value,
  output logic                    final_res,
  output logic                    overflowed
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = AW + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_BUILD    = 4'd1;
  localparam logic [3:0] ST_LOADNODE = 4'd2;
  localparam logic [3:0] ST_LEFT     = 4'd3;
  localparam logic [3:0] ST_RIGHT    = 4'd4;
  localparam logic [3:0] ST_CMP      = 4'd5;
  localparam logic [3:0] ST_PLACE    = 4'd6;
  localparam logic [3:0] ST_EXTRACT  = 4'd7;
  localparam logic [3:0] ST_EXROOT   = 4'd8;
  localparam logic [3:0] ST_EXLAST   = 4'd9;
  localparam logic [3:0] ST_OUTRD    = 4'd10;
  localparam logic [3:0] ST_OUTWT    = 4'd11;
  localparam logic [3:0] ST_OUTHOLD  = 4'd12;

  logic [3:0]    state;
  logic [CW-1:0] count;      // elements stored in this set
  logic          dropped;    // a beat was dropped in this set
  logic [CW-1:0] size;       // current heap size
  logic [CW-1:0] kcnt;       // build index, heap tail or output index
  logic [AW-1:0] node;       // hole being sifted down
  logic [IW-1:0] child;      // left child under inspection
  logic [AW-1:0] best_idx;
  value_t        best_val;
  value_t        node_val;   // value being sifted
  logic          moved;
  logic          extracting;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  value_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  value_t        ram_rdata;

  logic          in_beat;
  logic          out_beat;
  logic          room;
  logic [CW-1:0] count_next;
  logic [IW-1:0] left_idx;
  logic [IW-1:0] right_idx;
  logic          left_ok;
  logic          right_ok;
  logic          left_lt;
  logic          right_lt;
  logic [CW-1:0] kcnt_inc;
  logic [CW-1:0] kcnt_dec;

  assign in_stall = (state != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  assign room       = (count != MAX_CNT);
  assign count_next = room ? count + CW'(1) : count;

  // left child of node is 2*node+1, right child one further on
  assign left_idx  = {node, 1'b1};
  assign right_idx = child + IW'(1);
  assign left_ok   = left_idx < IW'(size);
  assign right_ok  = right_idx < IW'(size);
  assign left_lt   = value_less(ram_rdata, node_val);
  assign right_lt  = value_less(ram_rdata, best_val);
  assign kcnt_inc  = kcnt + CW'(1);
  assign kcnt_dec  = kcnt - CW'(1);

  // RAM access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wdata = node_val;
    ram_re    = 1'b0;
    ram_raddr = kcnt_dec[AW-1:0];
    case (state)
      ST_IDLE: begin
        ram_we    = in_beat && room;
        ram_waddr = count[AW-1:0];
        ram_wdata = value;
      end
      ST_BUILD: begin
        ram_re = (kcnt != '0);
      end
      ST_LEFT: begin
        ram_re    = left_ok;
        ram_raddr = left_idx[AW-1:0];
      end
      ST_RIGHT: begin
        if (right_ok) begin
          ram_re    = 1'b1;
          ram_raddr = right_idx[AW-1:0];
        end else begin
          ram_we    = left_lt;
          ram_wdata = ram_rdata;
        end
      end
      ST_CMP: begin
        if (right_lt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end else begin
          ram_we    = moved;
          ram_wdata = best_val;
        end
      end
      ST_PLACE: begin
        ram_we = 1'b1;
      end
      ST_EXTRACT: begin
        ram_re    = (kcnt > CW'(1));
        ram_raddr = '0;
      end
      ST_EXROOT: begin
        ram_re = 1'b1;
      end
      ST_EXLAST: begin
        // old root goes behind the heap
        ram_we    = 1'b1;
        ram_waddr = kcnt_dec[AW-1:0];
        ram_wdata = best_val;
      end
      ST_OUTRD: begin
        ram_re    = 1'b1;
        ram_raddr = kcnt[AW-1:0];
      end
      ST_OUTHOLD: begin
        ram_re    = out_beat && !final_res;
        ram_raddr = kcnt_inc[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
        ram_re = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            count <= count_next;
            if (!room) begin
              dropped <= 1'b1;
            end
            if (last) begin
              size       <= count_next;
              kcnt       <= count_next >> 1;
              extracting <= 1'b0;
              state      <= ST_BUILD;
            end
          end
        end
        ST_BUILD: begin
          // sift each inner node, last one first
          if (kcnt != '0) begin
            node  <= kcnt_dec[AW-1:0];
            kcnt  <= kcnt_dec;
            state <= ST_LOADNODE;
          end else begin
            extracting <= 1'b1;
            kcnt       <= size;
            state      <= ST_EXTRACT;
          end
        end
        ST_LOADNODE: begin
          node_val <= ram_rdata;
          state    <= ST_LEFT;
        end
        ST_LEFT: begin
          child <= left_idx;
          state <= left_ok ? ST_RIGHT : ST_PLACE;
        end
        ST_RIGHT: begin
          if (right_ok) begin
            // hold the smaller of node and left child
            best_val <= left_lt ? ram_rdata : node_val;
            best_idx <= left_lt ? child[AW-1:0] : node;
            moved    <= left_lt;
            state    <= ST_CMP;
          end else if (left_lt) begin
            node  <= child[AW-1:0];
            state <= ST_LEFT;
          end else begin
            state <= ST_PLACE;
          end
        end
        ST_CMP: begin
          if (right_lt) begin
            node  <= right_idx[AW-1:0];
            state <= ST_LEFT;
          end else if (moved) begin
            node  <= best_idx;
            state <= ST_LEFT;
          end else begin
            state <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          state <= extracting ? ST_EXTRACT : ST_BUILD;
        end
        ST_EXTRACT: begin
          if (kcnt > CW'(1)) begin
            state <= ST_EXROOT;
          end else begin
            kcnt  <= '0;
            state <= ST_OUTRD;
          end
        end
        ST_EXROOT: begin
          best_val <= ram_rdata;
          state    <= ST_EXLAST;
        end
        ST_EXLAST: begin
          // tail value becomes the root to sift down a shorter heap
          node_val <= ram_rdata;
          node     <= '0;
          size     <= kcnt_dec;
          kcnt     <= kcnt_dec;
          state    <= ST_LEFT;
        end
        ST_OUTRD: begin
          state <= ST_OUTWT;
        end
        ST_OUTWT: begin
          out_valid    <= 1'b1;
          sorted_value <= ram_rdata;
          final_res    <= (kcnt_inc == count);
          overflowed   <= dropped;
          state        <= ST_OUTHOLD;
        end
        ST_OUTHOLD: begin
          if (out_beat) begin
            out_valid <= 1'b0;
            if (final_res) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= ST_IDLE;
            end else begin
              kcnt  <= kcnt_inc;
              state <= ST_OUTWT;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  dhs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  `DHS_ASSERT_CLK(a_no_in_while_out, clk, rst, !(in_beat && out_valid), "input beat taken while a result waits")
  `DHS_ASSERT_CLK(a_count_range, clk, rst, count <= MAX_CNT, "element count beyond capacity")
  `DHS_ASSERT_NEXT(a_last_stalls, clk, rst, in_beat && last, in_stall && !out_valid, "last beat did not start the sort")
  `DHS_ASSERT_NEXT(a_final_idles, clk, rst, out_beat && final_res, !out_valid && !in_stall && (count == '0), "final beat did not end the set")

endmodule

`default_nettype wire

@@ rtl/dhs_ram.sv @@
// ----------------------------------------------------------------------------
// dhs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
